FILE: hdl/gffra_pkg.sv
// ----------------------------------------------------------------------------
// Grid first-fit rectangle allocator package
// Atlas and block geometry, derived widths and request codes shared by the
// allocator.
// ----------------------------------------------------------------------------
package gffra_pkg;

    // Atlas geometry in pixels and the block size that divides it.
    localparam int ATLAS_WIDTH  = 1024;
    localparam int ATLAS_HEIGHT = 1024;
    localparam int CELL_WIDTH   = 32;
    localparam int CELL_HEIGHT  = 32;

    // Shift amounts that turn a rounded pixel size into whole blocks.
    localparam int CELL_W_SHIFT = $clog2(CELL_WIDTH);
    localparam int CELL_H_SHIFT = $clog2(CELL_HEIGHT);

    // Block grid.
    localparam int GRID_COLS = ATLAS_WIDTH / CELL_WIDTH;
    localparam int GRID_ROWS = ATLAS_HEIGHT / CELL_HEIGHT;

    // Index widths and count widths (a count can hold the full size).
    localparam int COL_IDX_W = $clog2(GRID_COLS);
    localparam int ROW_IDX_W = $clog2(GRID_ROWS);
    localparam int COL_CNT_W = $clog2(GRID_COLS + 1);
    localparam int ROW_CNT_W = $clog2(GRID_ROWS + 1);

    // Stream field widths.
    localparam int SIZE_W      = 11;
    localparam int COORD_W     = 10;
    localparam int BLK_SUM_W   = SIZE_W + 1;
    localparam int IN_TDATA_W  = ((2 * SIZE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * COORD_W + 7) / 8) * 8;

    // Request kinds carried on the input tuser.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

endpackage

FILE: hdl/grid_first_fit_rect_allocator.sv
// ----------------------------------------------------------------------------
// Grid first-fit rectangle allocator
// Keeps a block occupancy map of a texture atlas and places rectangles at the
// first free block position in column-major order.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one request at a time. tuser selects allocate or
// clear; tdata carries the rectangle's pixel width and height. The master
// stream returns one response per request: tuser is the found flag and tdata
// the pixel origin (zero when nothing was placed).
// An allocate request scans one block column per cycle, checking all block
// rows of that column in parallel against a per-row run counter, then marks
// one column of the placed rectangle per cycle. Clear requests and refused
// sizes skip the scan and go straight to the response; a clear empties the
// whole map in the cycle it is accepted. The single occupancy column read port
// sets the scan pace. tready is high only while no request is in progress.
// Reset empties the map and drops any pending response. If the receiver
// stalls, the response holds in the output register; the next request is
// still taken and processed, but its response waits with tready low until
// the output register has been emptied.
// ----------------------------------------------------------------------------
module grid_first_fit_rect_allocator
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Request stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [10:0] req_width, [21:11] req_height, rest zero
    input  logic [gffra_pkg::IN_TDATA_W-1:0]       s_tdata,
    // [0] req_type
    input  logic                                   s_tuser,
    // Response stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [9:0] place_x, [19:10] place_y, rest zero
    output logic [gffra_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // [0] found
    output logic                                   m_tuser
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_RESP
    } state_t;

    typedef logic [gffra_pkg::GRID_ROWS-1:0] column_t;
    typedef logic [gffra_pkg::COL_CNT_W-1:0] run_t;

    // Registers
    state_t                              state_reg,    state_next;
    column_t                             occ_reg       [gffra_pkg::GRID_COLS];
    column_t                             occ_next      [gffra_pkg::GRID_COLS];
    run_t                                run_reg       [gffra_pkg::GRID_ROWS];
    run_t                                run_next      [gffra_pkg::GRID_ROWS];
    logic [gffra_pkg::COL_IDX_W-1:0]     col_ptr_reg,  col_ptr_next;
    logic [gffra_pkg::COL_IDX_W-1:0]     base_col_reg, base_col_next;
    logic [gffra_pkg::ROW_IDX_W-1:0]     row_reg,      row_next;
    logic [gffra_pkg::COL_CNT_W-1:0]     bw_reg,       bw_next;
    logic [gffra_pkg::COL_CNT_W-1:0]     cnt_reg,      cnt_next;
    logic [gffra_pkg::ROW_CNT_W-1:0]     row_lim_reg,  row_lim_next;
    column_t                             vmask_reg,    vmask_next;
    logic                                found_reg,    found_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic                                m_tuser_reg,  m_tuser_next;
    logic [gffra_pkg::OUT_TDATA_W-1:0]   m_tdata_reg,  m_tdata_next;

    // Request decode
    logic [gffra_pkg::SIZE_W-1:0]        req_w;
    logic [gffra_pkg::SIZE_W-1:0]        req_h;
    logic [gffra_pkg::BLK_SUM_W-1:0]     bw_full;
    logic [gffra_pkg::BLK_SUM_W-1:0]     bh_full;
    logic [gffra_pkg::GRID_ROWS:0]       one_shift;
    logic                                req_bad;

    // Scan datapath
    column_t                             col_sel;
    column_t                             fit_v;
    logic [gffra_pkg::GRID_ROWS-1:0]     hit;
    run_t                                new_run       [gffra_pkg::GRID_ROWS];
    logic [gffra_pkg::ROW_IDX_W-1:0]     hit_row;
    logic [gffra_pkg::COL_CNT_W-1:0]     start_col;
    logic [31:0]                         px_full;
    logic [31:0]                         py_full;
    logic [gffra_pkg::COORD_W-1:0]       px;
    logic [gffra_pkg::COORD_W-1:0]       py;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Round the pixel size up to whole blocks and check it against the grid.
    always_comb
    begin
        req_w     = s_tdata[gffra_pkg::SIZE_W-1:0];
        req_h     = s_tdata[2*gffra_pkg::SIZE_W-1:gffra_pkg::SIZE_W];
        bw_full   = (gffra_pkg::BLK_SUM_W'(req_w) +
                     gffra_pkg::BLK_SUM_W'(gffra_pkg::CELL_WIDTH - 1)) >>
                    gffra_pkg::CELL_W_SHIFT;
        bh_full   = (gffra_pkg::BLK_SUM_W'(req_h) +
                     gffra_pkg::BLK_SUM_W'(gffra_pkg::CELL_HEIGHT - 1)) >>
                    gffra_pkg::CELL_H_SHIFT;
        one_shift = (gffra_pkg::GRID_ROWS+1)'(1) << bh_full[gffra_pkg::ROW_CNT_W-1:0];
        req_bad   = (req_w == '0) || (req_h == '0) ||
                    (bw_full > gffra_pkg::BLK_SUM_W'(gffra_pkg::GRID_COLS)) ||
                    (bh_full > gffra_pkg::BLK_SUM_W'(gffra_pkg::GRID_ROWS));
    end

    // Row-parallel fit check of the current column and per-row run update.
    always_comb
    begin
        col_sel = occ_reg[col_ptr_reg];
        for (int r = 0; r < gffra_pkg::GRID_ROWS; r++)
        begin
            fit_v[r]   = ((col_sel & (vmask_reg << r)) == '0) &&
                         (gffra_pkg::ROW_CNT_W'(r) <= row_lim_reg);
            new_run[r] = fit_v[r] ? run_reg[r] + run_t'(1) : '0;
            hit[r]     = (new_run[r] >= bw_reg);
        end
    end

    // Lowest row that completes a fitting window in this column.
    always_comb
    begin
        hit_row = '0;
        for (int r = gffra_pkg::GRID_ROWS - 1; r >= 0; r--)
        begin
            if (hit[r])
            begin
                hit_row = gffra_pkg::ROW_IDX_W'(r);
            end
        end
        start_col = gffra_pkg::COL_CNT_W'(col_ptr_reg) + gffra_pkg::COL_CNT_W'(1) - bw_reg;
    end

    // Pixel origin of the placement, cut to the output width.
    always_comb
    begin
        px_full = 32'(base_col_reg) * 32'(gffra_pkg::CELL_WIDTH);
        py_full = 32'(row_reg) * 32'(gffra_pkg::CELL_HEIGHT);
        px      = found_reg ? px_full[gffra_pkg::COORD_W-1:0] : '0;
        py      = found_reg ? py_full[gffra_pkg::COORD_W-1:0] : '0;
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        run_next      = run_reg;
        col_ptr_next  = col_ptr_reg;
        base_col_next = base_col_reg;
        row_next      = row_reg;
        bw_next       = bw_reg;
        cnt_next      = cnt_reg;
        row_lim_next  = row_lim_reg;
        vmask_next    = vmask_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    found_next    = 1'b0;
                    base_col_next = '0;
                    row_next      = '0;
                    if (s_tuser == gffra_pkg::REQ_CLEAR)
                    begin
                        for (int c = 0; c < gffra_pkg::GRID_COLS; c++)
                        begin
                            occ_next[c] = '0;
                        end
                        state_next = ST_RESP;
                    end
                    else if (req_bad)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        bw_next      = bw_full[gffra_pkg::COL_CNT_W-1:0];
                        vmask_next   = column_t'(one_shift - (gffra_pkg::GRID_ROWS+1)'(1));
                        row_lim_next = gffra_pkg::ROW_CNT_W'(gffra_pkg::GRID_ROWS) -
                                       bh_full[gffra_pkg::ROW_CNT_W-1:0];
                        col_ptr_next = '0;
                        for (int r = 0; r < gffra_pkg::GRID_ROWS; r++)
                        begin
                            run_next[r] = '0;
                        end
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                run_next = new_run;
                if (hit != '0)
                begin
                    base_col_next = start_col[gffra_pkg::COL_IDX_W-1:0];
                    col_ptr_next  = start_col[gffra_pkg::COL_IDX_W-1:0];
                    row_next      = hit_row;
                    cnt_next      = bw_reg;
                    found_next    = 1'b1;
                    state_next    = ST_MARK;
                end
                else if (col_ptr_reg == gffra_pkg::COL_IDX_W'(gffra_pkg::GRID_COLS - 1))
                begin
                    found_next = 1'b0;
                    row_next   = '0;
                    state_next = ST_RESP;
                end
                else
                begin
                    col_ptr_next = col_ptr_reg + gffra_pkg::COL_IDX_W'(1);
                end
            end

            ST_MARK:
            begin
                // Mark one column of the placed rectangle per cycle.
                occ_next[col_ptr_reg] = col_sel | (vmask_reg << row_reg);
                cnt_next              = cnt_reg - gffra_pkg::COL_CNT_W'(1);
                if (cnt_reg == gffra_pkg::COL_CNT_W'(1))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    col_ptr_next = col_ptr_reg + gffra_pkg::COL_IDX_W'(1);
                end
            end

            ST_RESP:
            begin
                // Load the output register once the previous response is gone.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = found_reg;
                    m_tdata_next  = gffra_pkg::OUT_TDATA_W'({py, px});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, occupancy map and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tuser_reg  <= 1'b0;
            m_tdata_reg  <= '0;
            for (int c = 0; c < gffra_pkg::GRID_COLS; c++)
            begin
                occ_reg[c] <= '0;
            end
            for (int r = 0; r < gffra_pkg::GRID_ROWS; r++)
            begin
                run_reg[r] <= '0;
            end
            col_ptr_reg  <= '0;
            base_col_reg <= '0;
            row_reg      <= '0;
            bw_reg       <= '0;
            cnt_reg      <= '0;
            row_lim_reg  <= '0;
            vmask_reg    <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tuser_reg  <= m_tuser_next;
            m_tdata_reg  <= m_tdata_next;
            occ_reg      <= occ_next;
            run_reg      <= run_next;
            col_ptr_reg  <= col_ptr_next;
            base_col_reg <= base_col_next;
            row_reg      <= row_next;
            bw_reg       <= bw_next;
            cnt_reg      <= cnt_next;
            row_lim_reg  <= row_lim_next;
            vmask_reg    <= vmask_next;
            found_reg    <= found_next;
        end
    end

endmodule

FILE: bench/tb_grid_first_fit_rect_allocator.sv
// ----------------------------------------------------------------------------
// Grid first-fit rectangle allocator testbench
// Drives allocate and clear requests into the allocator, predicts every
// response from a private copy of the block occupancy map, and checks each
// response in order. Both stream sides idle at random, and the receiver also
// holds off for a long stretch so that the allocator backs up its input.
// ----------------------------------------------------------------------------
module tb_grid_first_fit_rect_allocator;

    // Drain wait sized for the longest request: a full scan and a full-width mark.
    localparam int DRAIN_CYCLES = 2 + 2 * gffra_pkg::GRID_COLS + 8;
    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_PER_PHASE = 142;

    // One response as the allocator reports it.
    typedef struct packed {
        logic                          found;
        logic [gffra_pkg::COORD_W-1:0] x;
        logic [gffra_pkg::COORD_W-1:0] y;
    } placement_t;

    // Keeps its own occupancy map and the placements still to be answered.
    class atlas_scoreboard;
        logic [gffra_pkg::GRID_ROWS-1:0] occupancy [gffra_pkg::GRID_COLS];
        placement_t                      expected_placements [$];
        int unsigned                     errors;

        function new();
            errors = 0;
            clear_map();
        endfunction

        function void clear_map();
            foreach (occupancy[c])
                occupancy[c] = '0;
        endfunction

        // First free window in column-major order; the blocks are reserved
        // when one is found.
        function placement_t place_first_fit(logic kind,
                                             logic [gffra_pkg::SIZE_W-1:0] w,
                                             logic [gffra_pkg::SIZE_W-1:0] h);
            int                              blk_w;
            int                              blk_h;
            logic [gffra_pkg::GRID_ROWS-1:0] row_mask;
            logic [gffra_pkg::GRID_ROWS-1:0] window;
            logic [gffra_pkg::GRID_ROWS-1:0] merged;
            placement_t                      p;
            p = '0;
            if (kind == gffra_pkg::REQ_CLEAR)
            begin
                clear_map();
                return p;
            end
            if (w == 0 || h == 0)
                return p;
            blk_w = (int'(w) + gffra_pkg::CELL_WIDTH - 1) / gffra_pkg::CELL_WIDTH;
            blk_h = (int'(h) + gffra_pkg::CELL_HEIGHT - 1) / gffra_pkg::CELL_HEIGHT;
            if (blk_w > gffra_pkg::GRID_COLS || blk_h > gffra_pkg::GRID_ROWS)
                return p;
            row_mask = {gffra_pkg::GRID_ROWS{1'b1}} >> (gffra_pkg::GRID_ROWS - blk_h);
            for (int col = 0; col + blk_w <= gffra_pkg::GRID_COLS; col++)
            begin
                // A row window is free when no covered column has a bit there.
                merged = '0;
                for (int a = 0; a < blk_w; a++)
                    merged |= occupancy[col + a];
                for (int row = 0; row + blk_h <= gffra_pkg::GRID_ROWS; row++)
                begin
                    window = row_mask << row;
                    if ((merged & window) == '0)
                    begin
                        for (int a = 0; a < blk_w; a++)
                            occupancy[col + a] |= window;
                        p.found = 1'b1;
                        p.x     = gffra_pkg::COORD_W'(col * gffra_pkg::CELL_WIDTH);
                        p.y     = gffra_pkg::COORD_W'(row * gffra_pkg::CELL_HEIGHT);
                        return p;
                    end
                end
            end
            return p;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task note_request(logic kind, logic [gffra_pkg::SIZE_W-1:0] w,
                          logic [gffra_pkg::SIZE_W-1:0] h);
            placement_t want;
            want = place_first_fit(kind, w, h);
            expected_placements = {expected_placements, want};
        endtask

        task check_response(logic found, logic [gffra_pkg::COORD_W-1:0] x,
                            logic [gffra_pkg::COORD_W-1:0] y);
            placement_t want;
            if (expected_placements.size() == 0)
            begin
                report($sformatf("response found=%0d x=%0d y=%0d with no request pending",
                                 found, x, y));
                return;
            end
            want = expected_placements.pop_front();
            if (found !== want.found)
                report($sformatf("found is %0d, expected %0d", found, want.found));
            if (x !== want.x)
                report($sformatf("place_x is %0d, expected %0d", x, want.x));
            if (y !== want.y)
                report($sformatf("place_y is %0d, expected %0d", y, want.y));
        endtask

        function int pending();
            return expected_placements.size();
        endfunction
    endclass

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [gffra_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                              s_tuser  = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [gffra_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                              m_tuser;

    int unsigned                       send_idle_pct = 0;
    int unsigned                       recv_idle_pct = 0;
    int unsigned                       hold_left     = 0;

    atlas_scoreboard                   sb = new();

    grid_first_fit_rect_allocator u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off while one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Response monitor.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_response(m_tuser, m_tdata[gffra_pkg::COORD_W-1:0],
                                  m_tdata[2*gffra_pkg::COORD_W-1:gffra_pkg::COORD_W]);
        end
    end

    // Offers one request, possibly after an idle gap, and notes it once taken.
    task automatic send_request(logic kind, logic [gffra_pkg::SIZE_W-1:0] w,
                                logic [gffra_pkg::SIZE_W-1:0] h);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= gffra_pkg::IN_TDATA_W'({h, w});
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(kind, w, h);
    endtask

    // Mostly small rectangles so many fit, with some large and malformed sizes.
    function automatic logic [gffra_pkg::SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return gffra_pkg::SIZE_W'($urandom_range(1, 96));
        else if (r < 90)
            return gffra_pkg::SIZE_W'($urandom_range(1, 400));
        else if (r < 96)
            return gffra_pkg::SIZE_W'($urandom_range(400, 1024));
        else if (r < 98)
            return '0;
        else
            return gffra_pkg::SIZE_W'($urandom_range(1025, 2047));
    endfunction

    // Random requests: mostly allocations, with a clear now and then.
    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 3)
                send_request(gffra_pkg::REQ_CLEAR, gffra_pkg::SIZE_W'($urandom),
                             gffra_pkg::SIZE_W'($urandom));
            else
                send_request(gffra_pkg::REQ_ALLOC, pick_size(), pick_size());
        end
    endtask

    // Stops offering and waits for every outstanding response.
    task automatic wait_all_answered();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Stimulus and end of run.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 33;
        recv_idle_pct = 62;

        // Directed: refused sizes, oversize, full map, clears, and both edges.
        send_request(gffra_pkg::REQ_ALLOC, 11'd1, 11'd1);
        send_request(gffra_pkg::REQ_ALLOC, 11'd32, 11'd32);
        send_request(gffra_pkg::REQ_ALLOC, 11'd33, 11'd1);
        send_request(gffra_pkg::REQ_ALLOC, 11'd0, 11'd5);
        send_request(gffra_pkg::REQ_ALLOC, 11'd5, 11'd0);
        send_request(gffra_pkg::REQ_ALLOC, 11'd0, 11'd0);
        send_request(gffra_pkg::REQ_ALLOC, 11'd2047, 11'd2047);
        send_request(gffra_pkg::REQ_ALLOC, 11'd1025, 11'd1);
        send_request(gffra_pkg::REQ_ALLOC, 11'd1, 11'd1025);
        send_request(gffra_pkg::REQ_ALLOC, 11'd1024, 11'd1024);
        send_request(gffra_pkg::REQ_CLEAR, 11'd2047, 11'd2047);
        send_request(gffra_pkg::REQ_ALLOC, 11'd1024, 11'd1024);
        send_request(gffra_pkg::REQ_ALLOC, 11'd1, 11'd1);
        send_request(gffra_pkg::REQ_CLEAR, 11'd0, 11'd0);
        send_request(gffra_pkg::REQ_ALLOC, 11'd992, 11'd1024);
        send_request(gffra_pkg::REQ_ALLOC, 11'd32, 11'd32);
        send_request(gffra_pkg::REQ_ALLOC, 11'd64, 11'd32);
        send_request(gffra_pkg::REQ_ALLOC, 11'd32, 11'd992);
        send_request(gffra_pkg::REQ_CLEAR, 11'd1, 11'd1);
        send_request(gffra_pkg::REQ_ALLOC, 11'd1024, 11'd992);
        send_request(gffra_pkg::REQ_ALLOC, 11'd1024, 11'd33);
        send_request(gffra_pkg::REQ_ALLOC, 11'd1000, 11'd20);
        send_request(gffra_pkg::REQ_ALLOC, 11'd1, 11'd1);
        send_request(gffra_pkg::REQ_CLEAR, 11'd1024, 11'd1024);

        send_random(RANDOM_PER_PHASE);
        wait_all_answered();

        send_idle_pct = 62;
        recv_idle_pct = 33;
        send_random(RANDOM_PER_PHASE);
        wait_all_answered();

        // No idling; partway through, the receiver holds off for a long time.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(RANDOM_PER_PHASE / 2);
        hold_left = 400;
        send_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
        wait_all_answered();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("grid_first_fit_rect_allocator regression: pass");
        else
            $display("grid_first_fit_rect_allocator regression: fail");
        $finish;
    end

    // Watchdog.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("ERROR: run did not finish in time");
        $display("grid_first_fit_rect_allocator regression: fail");
        $finish;
    end

endmodule
